FILE: hw/rtl/tcg_pkg.sv
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared constants, types and the palette for the text cell glyph renderer.
// ----------------------------------------------------------------------------
package tcg_pkg;

	localparam int TEXT_COLUMNS = 80;
	localparam int TEXT_ROWS    = 25;
	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 16;

	localparam int GRID_W = TEXT_COLUMNS * GLYPH_WIDTH;
	localparam int GRID_H = TEXT_ROWS * GLYPH_HEIGHT;

	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int LINE_W    = 4;
	localparam int BITS_W    = GLYPH_WIDTH;
	localparam int ATTR_W    = 8;
	localparam int ADDR_W    = 32;
	localparam int PITCH_W   = 16;
	localparam int DIM_W     = 13;
	localparam int PB_W      = 3;
	localparam int COLOR_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = $clog2(GLYPH_WIDTH);

	// pixel coordinates: origin up to half the screen plus the largest cell offset
	localparam int XW      = DIM_W + 1;
	localparam int YW      = DIM_W + 1;
	localparam int PROD_W  = YW + PITCH_W;
	localparam int XOFF_W  = XW + 2;

	localparam logic [PITCH_W-1:0] PITCH_RST  = PITCH_W'(2560);
	localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(400);
	localparam logic [PB_W-1:0]    PB_24BPP   = PB_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE      = 3'd0,
		REG_PITCH     = 3'd1,
		REG_WIDTH     = 3'd2,
		REG_HEIGHT    = 3'd3,
		REG_PIX_BYTES = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  base;
		logic [PITCH_W-1:0] pitch;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic               bpp4;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [XW-1:0]      x;
		logic               in_y;
		logic [BITS_W-1:0]  bits;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} pix_job_t;

	function automatic logic [COLOR_W-1:0] palette(input logic [3:0] idx);
		logic [COLOR_W-1:0] c;
		case (idx)
			4'h0: c = 24'h000000;
			4'h1: c = 24'h0000AA;
			4'h2: c = 24'h00AA00;
			4'h3: c = 24'h00AAAA;
			4'h4: c = 24'hAA0000;
			4'h5: c = 24'hAA00AA;
			4'h6: c = 24'hAA5500;
			4'h7: c = 24'hAAAAAA;
			4'h8: c = 24'h555555;
			4'h9: c = 24'h5555FF;
			4'hA: c = 24'h55FF55;
			4'hB: c = 24'h55FFFF;
			4'hC: c = 24'hFF5555;
			4'hD: c = 24'hFF55FF;
			4'hE: c = 24'hFFFF55;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/tcg_if.sv
// ----------------------------------------------------------------------------
// tcg interfaces
// Cell input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface tcg_cell_if import tcg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  cell_column;
	logic [ROW_W-1:0]  cell_row;
	logic [LINE_W-1:0] glyph_line;
	logic [BITS_W-1:0] glyph_bits;
	logic [ATTR_W-1:0] attribute;

	modport source (output valid, cell_column, cell_row, glyph_line, glyph_bits, attribute,
		input ready);
	modport sink (input valid, cell_column, cell_row, glyph_line, glyph_bits, attribute,
		output ready);
endinterface

interface tcg_pix_if import tcg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  byte_address;
	logic [COLOR_W-1:0] pixel_color;
	logic               fourth_byte_zero;
	logic               inside_screen;
	logic               last_pixel;

	modport source (output valid, byte_address, pixel_color, fourth_byte_zero,
		inside_screen, last_pixel, input ready);
	modport sink (input valid, byte_address, pixel_color, fourth_byte_zero,
		inside_screen, last_pixel, output ready);
endinterface

interface tcg_cfg_if import tcg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tcg_cfg.sv
// ----------------------------------------------------------------------------
// tcg_cfg
// Configuration register file.
// ----------------------------------------------------------------------------
module tcg_cfg import tcg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tcg_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.base   <= '0;
			regs_q.pitch  <= PITCH_RST;
			regs_q.width  <= WIDTH_RST;
			regs_q.height <= HEIGHT_RST;
			regs_q.bpp4   <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_BASE:      regs_q.base   <= cfg.data;
				REG_PITCH:     regs_q.pitch  <= cfg.data[PITCH_W-1:0];
				REG_WIDTH:     regs_q.width  <= cfg.data[DIM_W-1:0];
				REG_HEIGHT:    regs_q.height <= cfg.data[DIM_W-1:0];
				REG_PIX_BYTES: regs_q.bpp4   <= (cfg.data[PB_W-1:0] != PB_24BPP);
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/tcg_addr_pipe.sv
// ----------------------------------------------------------------------------
// tcg_addr_pipe
// Three-stage address pipeline: coordinates and palette, row multiply,
// line start address.
// ----------------------------------------------------------------------------
module tcg_addr_pipe import tcg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     regs,
	tcg_cell_if.sink cell_in,
	output logic     job_valid,
	output pix_job_t job,
	input  logic     job_take
);

	logic en1, en2, en3;

	logic [DIM_W-1:0] ox, oy;
	logic [XW-1:0]    x0;
	logic [YW-1:0]    y;

	logic               v_s1;
	logic [XW-1:0]      x0_s1;
	logic [YW-1:0]      y_s1;
	logic [BITS_W-1:0]  bits_s1;
	logic [COLOR_W-1:0] fg_s1, bg_s1;

	logic               v_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic [XOFF_W-1:0]  xoff_s2;
	logic [XW-1:0]      x0_s2;
	logic               iny_s2;
	logic [BITS_W-1:0]  bits_s2;
	logic [COLOR_W-1:0] fg_s2, bg_s2;

	logic               v_s3;
	pix_job_t           job_s3;

	assign en3 = !v_s3 || job_take;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign cell_in.ready = en1;

	// grid is centred when the screen is larger than it
	assign ox = (regs.width > DIM_W'(GRID_W)) ? (regs.width - DIM_W'(GRID_W)) >> 1 : '0;
	assign oy = (regs.height > DIM_W'(GRID_H)) ? (regs.height - DIM_W'(GRID_H)) >> 1 : '0;
	assign x0 = XW'(ox) + XW'(cell_in.cell_column) * XW'(GLYPH_WIDTH);
	assign y  = YW'(oy) + YW'(cell_in.cell_row) * YW'(GLYPH_HEIGHT) + YW'(cell_in.glyph_line);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cell_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x0_s1   <= x0;
			y_s1    <= y;
			bits_s1 <= cell_in.glyph_bits;
			fg_s1   <= palette(cell_in.attribute[3:0]);
			bg_s1   <= palette(cell_in.attribute[7:4]);
		end
		if (en2) begin
			prod_s2 <= PROD_W'(y_s1) * PROD_W'(regs.pitch);
			xoff_s2 <= regs.bpp4 ? {x0_s1, 2'b00}
			                     : XOFF_W'({x0_s1, 1'b0}) + XOFF_W'(x0_s1);
			iny_s2  <= (y_s1 < YW'(regs.height));
			x0_s2   <= x0_s1;
			bits_s2 <= bits_s1;
			fg_s2   <= fg_s1;
			bg_s2   <= bg_s1;
		end
		if (en3) begin
			job_s3.addr <= regs.base + ADDR_W'(prod_s2) + ADDR_W'(xoff_s2);
			job_s3.x    <= x0_s2;
			job_s3.in_y <= iny_s2;
			job_s3.bits <= bits_s2;
			job_s3.fg   <= fg_s2;
			job_s3.bg   <= bg_s2;
		end
	end

	assign job_valid = v_s3;
	assign job       = job_s3;

endmodule

FILE: hw/rtl/tcg_serializer.sv
// ----------------------------------------------------------------------------
// tcg_serializer
// Output register that walks one glyph line out as eight pixel beats.
// ----------------------------------------------------------------------------
module tcg_serializer import tcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       regs,
	input  logic       job_valid,
	input  pix_job_t   job,
	output logic       job_take,
	tcg_pix_if.source  pix_out
);

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(GLYPH_WIDTH - 1);

	logic               valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [XW-1:0]      x_q;
	logic               iny_q;
	logic [BITS_W-1:0]  bits_q;
	logic [COLOR_W-1:0] fg_q, bg_q;

	logic              fire, last;
	logic [ADDR_W-1:0] step;

	assign last     = (cnt_q == LAST_CNT);
	assign fire     = valid_q && pix_out.ready;
	assign job_take = !valid_q || (pix_out.ready && last);
	assign step     = regs.bpp4 ? ADDR_W'(4) : ADDR_W'(3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (job_take) begin
			valid_q <= job_valid;
			cnt_q   <= '0;
		end else if (fire) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			addr_q <= job.addr;
			x_q    <= job.x;
			iny_q  <= job.in_y;
			bits_q <= job.bits;
			fg_q   <= job.fg;
			bg_q   <= job.bg;
		end else if (fire) begin
			addr_q <= addr_q + step;
			x_q    <= x_q + XW'(1);
			bits_q <= bits_q << 1;
		end
	end

	assign pix_out.valid            = valid_q;
	assign pix_out.byte_address     = addr_q;
	assign pix_out.pixel_color      = bits_q[BITS_W-1] ? fg_q : bg_q;
	assign pix_out.fourth_byte_zero = regs.bpp4;
	assign pix_out.inside_screen    = iny_q && (x_q < XW'(regs.width));
	assign pix_out.last_pixel       = last;

	a_cnt_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last |=> valid_q && cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("pixel counter did not advance");

	a_addr_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last |=> addr_q == $past(addr_q) + $past(step))
		else $error("pixel address did not step by pixel size");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last && !job_valid |=> !valid_q)
		else $error("output beat repeated after last pixel");

endmodule

FILE: hw/rtl/text_cell_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer
// Turns one glyph line of a text cell into eight framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Each accepted cell beat yields eight pixel beats, left to right, and the output
// port takes one pixel beat per cycle while pix_out.ready is high, so the output
// port sets the cell beat rate. A cell beat passes three register stages
// (coordinates and palette, row multiply, line address) and the output register
// before its first pixel beat is presented; the stages keep taking cell beats
// while earlier pixels drain. Registers: 0 frame base, 1 row pitch, 2 screen
// width, 3 screen height, 4 bytes per pixel (3, else 4).
module text_cell_glyph_renderer import tcg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tcg_cfg_if.sink   cfg,
	tcg_cell_if.sink  cell_in,
	tcg_pix_if.source pix_out
);

	cfg_t     regs;
	logic     job_valid;
	logic     job_take;
	pix_job_t job;

	tcg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tcg_addr_pipe u_addr_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.cell_in   (cell_in),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	tcg_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.pix_out   (pix_out)
	);

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_cell_glyph_renderer: drives glyph-line cells
// and screen register writes, predicts the eight pixel writes of every cell
// and compares each pixel beat, field by field, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import tcg_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 8;
	localparam int PIPE_CYCLES  = 8;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_SETS  = 5;
	localparam int CELLS_PER_SET = 50;

	localparam logic [COLOR_W-1:0] VGA_RGB [16] = '{
		24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
		24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
		24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
		24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
	};

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               fourth_zero;
		logic               on_screen;
		logic               last;
	} pixel_write_t;

	logic clk;
	logic arst_n;

	tcg_cfg_if  cfg_bus ();
	tcg_cell_if cell_bus ();
	tcg_pix_if  pix_bus ();

	text_cell_glyph_renderer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.cell_in (cell_bus),
		.pix_out (pix_bus)
	);

	// screen registers as the block should hold them
	logic [ADDR_W-1:0]  scr_base;
	logic [PITCH_W-1:0] scr_pitch;
	logic [DIM_W-1:0]   scr_width;
	logic [DIM_W-1:0]   scr_height;
	logic [PB_W-1:0]    scr_pix_bytes;

	pixel_write_t pixel_writes_due [$];
	int  mismatches;
	int  cycle_count;
	bit  src_gaps;
	bit  sink_stalls;
	int  sink_hold;

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL text_cell_glyph_renderer");
			$finish;
		end
	end

	task automatic predict_glyph_row(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
		input logic [LINE_W-1:0] line, input logic [BITS_W-1:0] bits,
		input logic [ATTR_W-1:0] attr);
		logic [31:0] ox, oy, x0, y, row_addr, x, bpp;
		logic [COLOR_W-1:0] fg, bg;
		pixel_write_t w;
		fg = VGA_RGB[attr[3:0]];
		bg = VGA_RGB[attr[7:4]];
		bpp = (scr_pix_bytes == PB_24BPP) ? 32'd3 : 32'd4;
		ox = (32'(scr_width) > 32'(GRID_W)) ? (32'(scr_width) - 32'(GRID_W)) / 2 : 32'd0;
		oy = (32'(scr_height) > 32'(GRID_H)) ? (32'(scr_height) - 32'(GRID_H)) / 2 : 32'd0;
		x0 = ox + 32'(col) * 32'(GLYPH_WIDTH);
		y = oy + 32'(row) * 32'(GLYPH_HEIGHT) + 32'(line);
		row_addr = scr_base + y * 32'(scr_pitch);
		for (int k = 0; k < GLYPH_WIDTH; k++) begin
			x = x0 + 32'(k);
			w.addr = row_addr + x * bpp;
			w.color = bits[GLYPH_WIDTH-1-k] ? fg : bg;
			w.fourth_zero = (bpp == 32'd4);
			w.on_screen = (x < 32'(scr_width)) && (y < 32'(scr_height));
			w.last = (k == GLYPH_WIDTH - 1);
			pixel_writes_due.push_back(w);
		end
	endtask

	task automatic report(input string field, input logic [31:0] exp_val,
		input logic [31:0] act_val);
		mismatches++;
		$display("%0t: %s expected %h got %h", $time, field, exp_val, act_val);
	endtask

	// pixel sink: stall draw per beat
	initial begin
		pix_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pix_bus.ready && pix_bus.valid) begin
				sink_hold = sink_stalls ? $urandom_range(0, 15) : 0;
				if (sink_hold != 0)
					pix_bus.ready <= 1'b0;
			end else if (!pix_bus.ready) begin
				if (sink_hold > 0)
					sink_hold--;
				if (sink_hold == 0)
					pix_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : pixel_check
		pixel_write_t e;
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			if (pixel_writes_due.size() == 0) begin
				report("unexpected beat addr", 32'hx, pix_bus.byte_address);
			end else begin
				e = pixel_writes_due.pop_front();
				if (pix_bus.byte_address !== e.addr)
					report("byte_address", e.addr, pix_bus.byte_address);
				if (pix_bus.pixel_color !== e.color)
					report("pixel_color", 32'(e.color), 32'(pix_bus.pixel_color));
				if (pix_bus.fourth_byte_zero !== e.fourth_zero)
					report("fourth_byte_zero", 32'(e.fourth_zero), 32'(pix_bus.fourth_byte_zero));
				if (pix_bus.inside_screen !== e.on_screen)
					report("inside_screen", 32'(e.on_screen), 32'(pix_bus.inside_screen));
				if (pix_bus.last_pixel !== e.last)
					report("last_pixel", 32'(e.last), 32'(pix_bus.last_pixel));
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [ADDR_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_BASE:      scr_base = value;
			REG_PITCH:     scr_pitch = value[PITCH_W-1:0];
			REG_WIDTH:     scr_width = value[DIM_W-1:0];
			REG_HEIGHT:    scr_height = value[DIM_W-1:0];
			REG_PIX_BYTES: scr_pix_bytes = value[PB_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_screen(input logic [ADDR_W-1:0] base, input logic [PITCH_W-1:0] pitch,
		input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
		input logic [PB_W-1:0] pix_bytes);
		write_reg(REG_BASE, base);
		write_reg(REG_PITCH, 32'(pitch));
		write_reg(REG_WIDTH, 32'(width));
		write_reg(REG_HEIGHT, 32'(height));
		write_reg(REG_PIX_BYTES, 32'(pix_bytes));
	endtask

	task automatic send_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
		input logic [LINE_W-1:0] line, input logic [BITS_W-1:0] bits,
		input logic [ATTR_W-1:0] attr);
		int gap;
		gap = src_gaps ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			cell_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_bus.valid       <= 1'b1;
		cell_bus.cell_column <= col;
		cell_bus.cell_row    <= row;
		cell_bus.glyph_line  <= line;
		cell_bus.glyph_bits  <= bits;
		cell_bus.attribute   <= attr;
		do @(posedge clk); while (!cell_bus.ready);
		predict_glyph_row(col, row, line, bits, attr);
	endtask

	// mostly cells on the grid, some beyond it
	task automatic send_random_cells(input int count);
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		repeat (count) begin
			col = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(0, 127))
				: COL_W'($urandom_range(0, TEXT_COLUMNS - 1));
			row = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom_range(0, 31))
				: ROW_W'($urandom_range(0, TEXT_ROWS - 1));
			send_cell(col, row, LINE_W'($urandom_range(0, 15)), BITS_W'($urandom),
				ATTR_W'($urandom));
		end
	endtask

	task automatic finish_phase();
		cell_bus.valid <= 1'b0;
		while (pixel_writes_due.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_screen();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		send_cell(7'd0, 5'd0, 4'd0, 8'h80, 8'h0F);
		send_cell(7'd79, 5'd24, 4'd15, 8'h01, 8'hF0);
		send_cell(7'd127, 5'd31, 4'd15, 8'hFF, 8'h7F);
		send_cell(7'd80, 5'd0, 4'd0, 8'h00, 8'h1E);
		send_cell(7'd0, 5'd25, 4'd0, 8'hAA, 8'hC3);
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		// every palette entry as foreground and as background
		for (int i = 0; i < 16; i++)
			send_cell(COL_W'(i * 5), ROW_W'(i), LINE_W'(i), i[0] ? 8'h55 : 8'hAA,
				{4'(i), ~4'(i)});
		finish_phase();
	endtask

	task automatic test_register_extremes();
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		// widest screen, address wrap, 24bpp
		set_screen(32'hFFFF_FFF0, 16'hFFFF, 13'h1FFF, 13'h1FFF, PB_24BPP);
		send_cell(7'd0, 5'd0, 4'd0, 8'hF0, 8'h9A);
		send_cell(7'd127, 5'd31, 4'd15, 8'h0F, 8'h5B);
		send_random_cells(4);
		finish_phase();
		// empty screen, odd pixel size acting as 32bpp
		set_screen(32'h0, 16'h0, 13'h0, 13'h0, 3'd7);
		send_cell(7'd0, 5'd0, 4'd0, 8'hFF, 8'hFF);
		send_random_cells(3);
		finish_phase();
		// odd centring remainder, pixel size zero
		set_screen(32'h1000_0000, 16'd1923, 13'd641, 13'd401, 3'd0);
		send_cell(7'd0, 5'd0, 4'd0, 8'h81, 8'h42);
		send_cell(7'd79, 5'd24, 4'd15, 8'h18, 8'h24);
		send_random_cells(4);
		finish_phase();
		// screen smaller than the grid
		set_screen(32'h0004_0000, 16'd1280, 13'd320, 13'd200, 3'd4);
		send_cell(7'd39, 5'd12, 4'd7, 8'hC3, 8'h70);
		send_cell(7'd40, 5'd12, 4'd8, 8'h3C, 8'h07);
		send_random_cells(4);
		finish_phase();
	endtask

	task automatic test_random_screens();
		logic [DIM_W-1:0] width, height;
		logic [PB_W-1:0]  pix_bytes;
		logic [PITCH_W-1:0] pitch;
		for (int s = 0; s < RANDOM_SETS; s++) begin
			src_gaps = (s == 0) ? 1'b0 : (s == 1) ? 1'b1 : 1'($urandom);
			sink_stalls = (s == 0) ? 1'b0 : (s == 1) ? 1'b1 : 1'($urandom);
			case ($urandom_range(0, 2))
				0: begin
					width = 13'd640;
					height = 13'd400;
				end
				1: begin
					width = DIM_W'($urandom_range(0, 8191));
					height = DIM_W'($urandom_range(0, 8191));
				end
				default: begin
					width = DIM_W'($urandom_range(600, 2000));
					height = DIM_W'($urandom_range(380, 1200));
				end
			endcase
			pix_bytes = ($urandom_range(0, 5) == 0) ? PB_W'($urandom_range(0, 7))
				: PB_W'($urandom_range(3, 4));
			pitch = ($urandom_range(0, 1) == 0) ? PITCH_W'($urandom)
				: PITCH_W'(32'(width) * 4 + $urandom_range(0, 64));
			set_screen(ADDR_W'($urandom), pitch, width, height, pix_bytes);
			send_random_cells(CELLS_PER_SET);
			finish_phase();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_BASE;
		cfg_bus.data <= '0;
		cell_bus.valid <= 1'b0;
		cell_bus.cell_column <= '0;
		cell_bus.cell_row <= '0;
		cell_bus.glyph_line <= '0;
		cell_bus.glyph_bits <= '0;
		cell_bus.attribute <= '0;
		scr_base = '0;
		scr_pitch = PITCH_RST;
		scr_width = WIDTH_RST;
		scr_height = HEIGHT_RST;
		scr_pix_bytes = PB_W'(4);
		mismatches = 0;
		cycle_count = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_screen();
		test_register_extremes();
		test_random_screens();

		if (pixel_writes_due.size() != 0)
			report("beats still owed", 32'(pixel_writes_due.size()), 32'd0);
		if (mismatches == 0)
			$display("PASS text_cell_glyph_renderer");
		else
			$display("FAIL text_cell_glyph_renderer");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/tcg_pkg.sv
hw/rtl/tcg_if.sv
hw/rtl/tcg_cfg.sv
hw/rtl/tcg_addr_pipe.sv
hw/rtl/tcg_serializer.sv
hw/rtl/text_cell_glyph_renderer.sv
tb/sv/tb_top.sv
